FILE: src/chtb_pkg.sv
// chtb_pkg: shared constants for the canonical Huffman table builder.
// No dependencies.
package chtb_pkg;

	localparam int NUM_SLOTS = 16;
	localparam int CODE_W    = 16;
	localparam int LEN_W     = 5;
	localparam int TOTAL_W   = 9;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = 9'd511;

	localparam logic [1:0] OP_COUNT  = 2'd0;
	localparam logic [1:0] OP_ASSIGN = 2'd1;
	localparam logic [1:0] OP_LOOKUP = 2'd2;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_FIND   = 2'd1;
	localparam logic [1:0] ST_LOOKUP = 2'd2;

endpackage

FILE: src/chtb_ram.sv
// chtb_ram: generic single-clock RAM, one write port, one read port,
// registered read data. No dependencies.
module chtb_ram #(
	parameter int WIDTH = 21,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: src/canonical_huffman_table_builder.sv
// Canonical Huffman table builder top level.
// Depends on chtb_pkg and chtb_ram.
//
// A table is loaded by sixteen count transfers (op 0, lengths 1 to 16), then by the
// ordered symbols (op 1), each of which gets the next canonical code; op 2 looks a
// symbol up. Codes and lengths live in a SYMBOL_COUNT-entry RAM; valid bits and the
// sixteen counts are flip-flops, cleared at reset and by the first count of a table
// itself, so there is no clearing pass. Op 0 and op 3 answer straight from idle;
// op 2 passes through a lookup state for the registered RAM read; op 1 answers from
// idle while the current length still has codes left, otherwise a find state searches
// the count slots one by one and rejects the symbol when the search runs out. One
// item is in work at a time; the next item is taken no earlier than the edge at
// which the previous result transfers out of the output register.
module canonical_huffman_table_builder
	import chtb_pkg::*;
#(
	parameter int SYMBOL_COUNT    = 256,
	parameter int MAX_CODE_LENGTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  logic [1:0]        op,
	input  logic [7:0]        length_count,
	input  logic [7:0]        symbol,
	output logic              result_valid,
	input  logic              result_stall,
	output logic              status,
	output logic [CODE_W-1:0] code_bits,
	output logic [LEN_W-1:0]  code_length
);

	localparam int AW = $clog2(SYMBOL_COUNT);

	logic [1:0]               state_q;
	logic                     result_valid_q;
	logic                     status_q;
	logic [CODE_W-1:0]        code_q;
	logic [LEN_W-1:0]         len_q;
	logic [SYMBOL_COUNT-1:0]  valid_q;
	logic [7:0]               counts_q [NUM_SLOTS];
	logic [LEN_W-1:0]         slot_q;
	logic [TOTAL_W-1:0]       declared_q;
	logic [TOTAL_W-1:0]       assigned_q;
	logic [LEN_W-1:0]         cur_len_q;
	logic [7:0]               remaining_q;
	logic [CODE_W:0]          next_code_q;
	logic                     first_q;
	logic [AW-1:0]            sym_q;
	logic                     hit_s1;

	logic                     accept;
	logic                     sym_ok;
	logic [AW-1:0]            addr;
	logic [3:0]               cnt_idx;
	logic [7:0]               cnt_rd;
	logic                     a_go;
	logic                     a_fail;
	logic [LEN_W-1:0]         a_len;
	logic [CODE_W:0]          a_code;
	logic [7:0]               a_rem;
	logic                     restart;
	logic [LEN_W-1:0]         slot_base;
	logic [7:0]               cnt_eff;
	logic [TOTAL_W:0]         decl_sum;
	logic [CODE_W+LEN_W-1:0]  ram_rdata;
	logic [AW-1:0]            ram_waddr;

	assign item_stall   = (state_q != ST_IDLE) || (result_valid_q && result_stall);
	assign accept       = item_valid && !item_stall;
	assign result_valid = result_valid_q;
	assign status       = status_q;
	assign code_bits    = code_q;
	assign code_length  = len_q;

	assign sym_ok = {1'b0, symbol} < 9'(SYMBOL_COUNT);
	assign addr   = symbol[AW-1:0];

	// Length search: first look re-reads the current slot, later looks step up.
	assign cnt_idx = first_q ? 4'(cur_len_q - 5'd1) : cur_len_q[3:0];
	assign cnt_rd  = counts_q[cnt_idx];

	always_comb begin
		a_go   = 1'b0;
		a_fail = 1'b0;
		a_len  = cur_len_q;
		a_code = next_code_q;
		a_rem  = remaining_q;
		if (state_q == ST_IDLE) begin
			a_go = accept && (op == OP_ASSIGN) && sym_ok && (assigned_q < declared_q)
				&& (remaining_q != 8'd0);
		end else if (state_q == ST_FIND) begin
			if (first_q) begin
				a_rem = cnt_rd;
				a_go  = cnt_rd != 8'd0;
			end else if (cur_len_q < 5'(MAX_CODE_LENGTH)) begin
				a_len  = cur_len_q + 5'd1;
				a_code = {next_code_q[CODE_W-1:0], 1'b0};
				a_rem  = cnt_rd;
				a_go   = cnt_rd != 8'd0;
			end else begin
				a_fail = 1'b1;
			end
		end
	end

	assign restart   = (slot_q == 5'd0) || (slot_q >= 5'(NUM_SLOTS));
	assign slot_base = restart ? 5'd0 : slot_q;
	assign cnt_eff   = (slot_base >= 5'(MAX_CODE_LENGTH)) ? 8'd0 : length_count;
	assign decl_sum  = {1'b0, restart ? 9'd0 : declared_q} + {2'b00, cnt_eff};

	assign ram_waddr = (state_q == ST_IDLE) ? addr : sym_q;

	chtb_ram #(
		.WIDTH (CODE_W + LEN_W),
		.DEPTH (SYMBOL_COUNT)
	) u_entry_ram (
		.clk   (clk),
		.we    (a_go),
		.waddr (ram_waddr),
		.wdata ({a_code[CODE_W-1:0], a_len}),
		.raddr (addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
			status_q       <= 1'b0;
			code_q         <= '0;
			len_q          <= '0;
			valid_q        <= '0;
			for (int i = 0; i < NUM_SLOTS; i++) begin
				counts_q[i] <= 8'd0;
			end
			slot_q         <= 5'd0;
			declared_q     <= '0;
			assigned_q     <= '0;
			cur_len_q      <= 5'd1;
			remaining_q    <= 8'd0;
			next_code_q    <= '0;
			first_q        <= 1'b0;
			sym_q          <= '0;
			hit_s1         <= 1'b0;
		end else begin
			if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (op)
							OP_COUNT: begin
								if (restart) begin
									valid_q     <= '0;
									for (int i = 0; i < NUM_SLOTS; i++) begin
										counts_q[i] <= 8'd0;
									end
									assigned_q  <= '0;
									cur_len_q   <= 5'd1;
									remaining_q <= 8'd0;
									next_code_q <= '0;
								end
								counts_q[slot_base[3:0]] <= cnt_eff;
								declared_q <= decl_sum[TOTAL_W] ? TOTAL_MAX
									: decl_sum[TOTAL_W-1:0];
								slot_q <= slot_base + 5'd1;
								result_valid_q <= 1'b1;
								status_q <= 1'b0;
								code_q   <= '0;
								len_q    <= '0;
							end
							OP_ASSIGN: begin
								if (!sym_ok || assigned_q >= declared_q) begin
									result_valid_q <= 1'b1;
									status_q <= 1'b1;
									code_q   <= '0;
									len_q    <= '0;
								end else if (remaining_q == 8'd0) begin
									sym_q   <= addr;
									first_q <= assigned_q == '0;
									state_q <= ST_FIND;
								end
							end
							OP_LOOKUP: begin
								hit_s1  <= sym_ok && valid_q[addr];
								state_q <= ST_LOOKUP;
							end
							default: begin
								result_valid_q <= 1'b1;
								status_q <= 1'b0;
								code_q   <= '0;
								len_q    <= '0;
							end
						endcase
					end
				end
				ST_FIND: begin
					if (a_go) begin
						state_q <= ST_IDLE;
					end else if (a_fail) begin
						state_q        <= ST_IDLE;
						result_valid_q <= 1'b1;
						status_q <= 1'b1;
						code_q   <= '0;
						len_q    <= '0;
					end else if (first_q) begin
						first_q <= 1'b0;
					end else begin
						// empty length: step up, code shifts left
						cur_len_q   <= a_len;
						next_code_q <= a_code;
					end
				end
				ST_LOOKUP: begin
					state_q        <= ST_IDLE;
					result_valid_q <= 1'b1;
					status_q       <= 1'b0;
					code_q <= hit_s1 ? ram_rdata[CODE_W+LEN_W-1:LEN_W] : '0;
					len_q  <= hit_s1 ? ram_rdata[LEN_W-1:0] : '0;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (a_go) begin
				valid_q[ram_waddr] <= 1'b1;
				cur_len_q      <= a_len;
				next_code_q    <= a_code + 17'd1;
				remaining_q    <= a_rem - 8'd1;
				assigned_q     <= assigned_q + 9'd1;
				first_q        <= 1'b0;
				result_valid_q <= 1'b1;
				status_q       <= 1'b0;
				code_q         <= a_code[CODE_W-1:0];
				len_q          <= a_len;
			end
		end
	end

endmodule

FILE: bench/testbench.sv
// Self-checking bench for canonical_huffman_table_builder: directed rows, then random tables.
// Keeps its own copy of the code table to predict every result transfer.
// Depends on chtb_pkg and the builder RTL.
module testbench
	import chtb_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD     = 8;
	localparam int SYM_COUNT      = 256;
	localparam int MAX_LEN        = 16;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int TAIL_CYCLES    = 24;
	localparam int ITEMS_PER_PASS = 200;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic              status;
		logic [CODE_W-1:0] code;
		logic [LEN_W-1:0]  len;
	} huff_result_t;

	typedef struct packed {
		logic [1:0]   op;
		logic [7:0]   cnt;
		logic [7:0]   sym;
		logic         typed;
		huff_result_t want;
	} dir_row_t;

	localparam huff_result_t NIL    = '0;
	localparam huff_result_t REJECT = '{status: 1'b1, code: '0, len: '0};

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              item_valid   = 1'b0;
	logic              item_stall;
	logic [1:0]        op           = OP_COUNT;
	logic [7:0]        length_count = 8'd0;
	logic [7:0]        symbol       = 8'd0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	logic              status;
	logic [CODE_W-1:0] code_bits;
	logic [LEN_W-1:0]  code_length;

	// predicted table state
	bit                sym_valid [SYM_COUNT];
	bit                ever_written [SYM_COUNT];
	logic [CODE_W-1:0] sym_code [SYM_COUNT];
	logic [LEN_W-1:0]  sym_len [SYM_COUNT];
	logic [7:0]        len_counts [NUM_SLOTS];
	logic [7:0]        written_syms [$];
	int                filled_slots;
	int                declared_codes;
	int                assigned_codes;
	int                code_len_now;
	int                left_at_len;
	logic [16:0]       code_ctr;

	huff_result_t      codes_due [$];
	int                errors;
	int                items_sent;
	int                quiet_cycles;
	int                send_gap_pct;
	int                recv_stall_pct;

	// extremes, every op, a reject case, overwrite and the table restart
	dir_row_t directed_rows [25] = '{
		'{OP_UNUSED, 8'hFF, 8'hFF, 1'b1, NIL},
		'{OP_ASSIGN, 8'hFF, 8'h00, 1'b1, REJECT},
		'{OP_COUNT,  8'd0,  8'h55, 1'b1, NIL},
		'{OP_COUNT,  8'd2,  8'hAA, 1'b1, NIL},
		'{OP_COUNT,  8'd1,  8'h55, 1'b1, NIL},
		'{OP_COUNT,  8'd0,  8'hAA, 1'b1, NIL},
		'{OP_COUNT,  8'd0,  8'h55, 1'b1, NIL},
		'{OP_COUNT,  8'd0,  8'hAA, 1'b1, NIL},
		'{OP_COUNT,  8'd0,  8'h55, 1'b1, NIL},
		'{OP_COUNT,  8'd0,  8'hAA, 1'b1, NIL},
		'{OP_COUNT,  8'd0,  8'h55, 1'b1, NIL},
		'{OP_COUNT,  8'd0,  8'hAA, 1'b1, NIL},
		'{OP_COUNT,  8'd0,  8'h55, 1'b1, NIL},
		'{OP_COUNT,  8'd0,  8'hAA, 1'b1, NIL},
		'{OP_COUNT,  8'd0,  8'h55, 1'b1, NIL},
		'{OP_COUNT,  8'd0,  8'hAA, 1'b1, NIL},
		'{OP_COUNT,  8'd0,  8'h55, 1'b1, NIL},
		'{OP_COUNT,  8'hFF, 8'hAA, 1'b1, NIL},
		'{OP_ASSIGN, 8'h00, 8'hFF, 1'b0, NIL},
		'{OP_ASSIGN, 8'h00, 8'h00, 1'b0, NIL},
		'{OP_ASSIGN, 8'h00, 8'h80, 1'b0, NIL},
		'{OP_ASSIGN, 8'h00, 8'hFF, 1'b0, NIL},
		'{OP_LOOKUP, 8'h00, 8'hFF, 1'b0, NIL},
		'{OP_COUNT,  8'd0,  8'h00, 1'b1, NIL},
		'{OP_LOOKUP, 8'h00, 8'h00, 1'b1, NIL}
	};

	canonical_huffman_table_builder #(
		.SYMBOL_COUNT(SYM_COUNT),
		.MAX_CODE_LENGTH(MAX_LEN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.op(op),
		.length_count(length_count),
		.symbol(symbol),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.status(status),
		.code_bits(code_bits),
		.code_length(code_length)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic void clear_table();
		for (int i = 0; i < SYM_COUNT; i++) sym_valid[i] = 1'b0;
		for (int i = 0; i < NUM_SLOTS; i++) len_counts[i] = 8'd0;
		filled_slots   = 0;
		declared_codes = 0;
		assigned_codes = 0;
		code_len_now   = 1;
		left_at_len    = 0;
		code_ctr       = '0;
	endfunction

	// walk to the next length that still has codes; empty lengths shift the code
	function automatic bit seek_length();
		if (left_at_len != 0) return 1'b1;
		if (assigned_codes == 0) begin
			if (code_len_now >= 1 && code_len_now <= NUM_SLOTS)
				left_at_len = int'(len_counts[code_len_now - 1]);
			if (left_at_len != 0) return 1'b1;
		end
		while (code_len_now < MAX_LEN && code_len_now < NUM_SLOTS) begin
			code_len_now++;
			code_ctr    = {code_ctr[15:0], 1'b0};
			left_at_len = int'(len_counts[code_len_now - 1]);
			if (left_at_len != 0) return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic huff_result_t code_for_item(logic [1:0] opc, logic [7:0] cnt,
			logic [7:0] sym);
		huff_result_t r;
		int c;
		r = NIL;
		c = int'(cnt);
		case (opc)
			OP_COUNT: begin
				if (filled_slots == 0 || filled_slots >= NUM_SLOTS) clear_table();
				if (filled_slots + 1 > MAX_LEN) c = 0;
				len_counts[filled_slots] = c[7:0];
				declared_codes = declared_codes + c;
				if (declared_codes > int'(TOTAL_MAX)) declared_codes = int'(TOTAL_MAX);
				filled_slots++;
			end
			OP_ASSIGN: begin
				if (sym >= SYM_COUNT || assigned_codes >= declared_codes) begin
					r.status = 1'b1;
				end else if (!seek_length()) begin
					r.status = 1'b1;
				end else begin
					r.code = code_ctr[15:0];
					r.len  = code_len_now[LEN_W-1:0];
					sym_valid[sym] = 1'b1;
					sym_code[sym]  = r.code;
					sym_len[sym]   = r.len;
					if (!ever_written[sym]) begin
						ever_written[sym] = 1'b1;
						written_syms.push_back(sym);
					end
					left_at_len--;
					code_ctr = code_ctr + 17'd1;
					assigned_codes++;
				end
			end
			OP_LOOKUP: begin
				if (sym < SYM_COUNT && sym_valid[sym]) begin
					r.code = sym_code[sym];
					r.len  = sym_len[sym];
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic send_item(logic [1:0] opc, logic [7:0] cnt, logic [7:0] sym,
			logic typed, huff_result_t want);
		huff_result_t predicted;
		while ($urandom_range(99) < send_gap_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid   <= 1'b1;
		op           <= opc;
		length_count <= cnt;
		symbol       <= sym;
		predicted = code_for_item(opc, cnt, sym);
		codes_due.push_back(typed ? want : predicted);
		do @(posedge clk); while (item_stall);
		items_sent++;
	endtask

	task automatic send_random(logic [1:0] opc, logic [7:0] cnt, logic [7:0] sym);
		send_item(opc, cnt, sym, 1'b0, NIL);
	endtask

	// lookups only touch symbols that were written at least once
	task automatic send_lookup_or_assign(bit want_lookup);
		if (want_lookup && written_syms.size() != 0)
			send_random(OP_LOOKUP, 8'($urandom_range(255)),
				written_syms[$urandom_range(written_syms.size() - 1)]);
		else
			send_random(OP_ASSIGN, 8'($urandom_range(255)), 8'($urandom_range(255)));
	endtask

	task automatic run_table();
		int pick;
		int n;
		logic [7:0] c;
		// close out a partial table so the next count starts a fresh one
		while (filled_slots != 0 && filled_slots < NUM_SLOTS)
			send_random(OP_COUNT, 8'd0, 8'($urandom_range(255)));
		for (int i = 0; i < NUM_SLOTS; i++) begin
			pick = int'($urandom_range(99));
			if (pick < 12) c = 8'($urandom_range(255));
			else if (pick < 40) c = 8'($urandom_range(4, 1));
			else c = 8'd0;
			send_random(OP_COUNT, c, 8'($urandom_range(255)));
		end
		n = (declared_codes < 40 ? declared_codes : 40) + int'($urandom_range(3));
		repeat (n) send_lookup_or_assign($urandom_range(3) == 0);
	endtask

	task automatic run_noise();
		logic [1:0] opc;
		repeat ($urandom_range(6, 1)) begin
			opc = 2'($urandom_range(3));
			if (opc == OP_LOOKUP) send_lookup_or_assign(1'b1);
			else send_random(opc, 8'($urandom_range(255)), 8'($urandom_range(255)));
		end
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		@(posedge clk);
		while (codes_due.size() != 0) @(posedge clk);
	endtask

	// result check and stall generation, plus the stuck-handshake watchdog
	always @(posedge clk) begin
		huff_result_t exp_r;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (codes_due.size() == 0) begin
					$error("result transfer with nothing expected: status %0d code %h len %0d",
						status, code_bits, code_length);
					errors++;
				end else begin
					exp_r = codes_due.pop_front();
					if (status !== exp_r.status) begin
						$error("status: expected %0d, got %0d", exp_r.status, status);
						errors++;
					end
					if (code_bits !== exp_r.code) begin
						$error("code_bits: expected %h, got %h", exp_r.code, code_bits);
						errors++;
					end
					if (code_length !== exp_r.len) begin
						$error("code_length: expected %0d, got %0d", exp_r.len, code_length);
						errors++;
					end
				end
			end
			result_stall <= ($urandom_range(99) < recv_stall_pct);
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("canonical_huffman_table_builder verification failed");
				$finish;
			end
		end
	end

	initial begin
		int gap_plan [3];
		int stall_plan [3];
		gap_plan   = '{6, 49, 0};
		stall_plan = '{49, 6, 0};
		errors         = 0;
		items_sent     = 0;
		quiet_cycles   = 0;
		send_gap_pct   = gap_plan[0];
		recv_stall_pct = stall_plan[0];
		for (int i = 0; i < SYM_COUNT; i++) ever_written[i] = 1'b0;
		clear_table();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_item(directed_rows[i].op, directed_rows[i].cnt, directed_rows[i].sym,
				directed_rows[i].typed, directed_rows[i].want);

		for (int pass = 0; pass < 3; pass++) begin
			send_gap_pct   = gap_plan[pass];
			recv_stall_pct = stall_plan[pass];
			while (items_sent < ITEMS_PER_PASS * (pass + 1)) begin
				if ($urandom_range(99) < 80) run_table();
				else run_noise();
			end
			// sender holds off until every expected result has come back
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("canonical_huffman_table_builder verification clean");
		else
			$display("canonical_huffman_table_builder verification failed");
		$finish;
	end

endmodule
